@@ hw/rtl/emt_pkg.sv @@
// ----------------------------------------------------------------------------
// emt_pkg
// Shared constants, codes and types of the encoder angle and motion tracker.
// ----------------------------------------------------------------------------
package emt_pkg;

    localparam int ANGLE_BITS_DEF   = 12;
    localparam int COUNTER_BITS_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int OFFSET_W    = 12;
    localparam int THRESHOLD_W = 11;
    localparam int WINDOW_W    = 12;
    localparam int MIN_READS_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_READS = 3'd5;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 11'd5;
    localparam logic [WINDOW_W-1:0]    WINDOW_RST    = 12'd57;
    localparam logic [MIN_READS_W-1:0] MIN_READS_RST = 8'd10;

    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_CW   = 2'b01;
    localparam logic [1:0] DIR_CCW  = 2'b11;

    localparam logic [1:0] MAG_OK     = 2'd0;
    localparam logic [1:0] MAG_WEAK   = 2'd1;
    localparam logic [1:0] MAG_STRONG = 2'd2;
    localparam logic [1:0] MAG_NONE   = 2'd3;

    typedef struct packed {
        logic [OFFSET_W-1:0]    offset_counts;
        logic                   invert_direction;
        logic                   sensor_present;
        logic [THRESHOLD_W-1:0] move_limit;
        logic [WINDOW_W-1:0]    arrive_window;
        logic [MIN_READS_W-1:0] min_reads_for_rate;
    } cfg_t;

    typedef struct packed {
        logic [1:0] expected_direction;
        logic [1:0] magnet_code;
    } calc_t;

    typedef struct packed {
        logic [1:0] rotation;
        logic       movement_seen;
        logic       rate_ok;
    } trk_status_t;

endpackage

@@ hw/rtl/emt_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// emt_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module emt_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [emt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [emt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output emt_pkg::cfg_t                    cfg
);

    emt_pkg::cfg_t cfg_reg;
    emt_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                emt_pkg::CFG_OFFSET: begin
                    cfg_next.offset_counts = cfg_data[emt_pkg::OFFSET_W-1:0];
                end
                emt_pkg::CFG_INVERT: begin
                    cfg_next.invert_direction = cfg_data[0];
                end
                emt_pkg::CFG_PRESENT: begin
                    cfg_next.sensor_present = cfg_data[0];
                end
                emt_pkg::CFG_THRESHOLD: begin
                    cfg_next.move_limit = cfg_data[emt_pkg::THRESHOLD_W-1:0];
                end
                emt_pkg::CFG_WINDOW: begin
                    cfg_next.arrive_window = cfg_data[emt_pkg::WINDOW_W-1:0];
                end
                emt_pkg::CFG_MIN_READS: begin
                    cfg_next.min_reads_for_rate = cfg_data[emt_pkg::MIN_READS_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset_counts      <= '0;
            cfg_reg.invert_direction   <= 1'b0;
            cfg_reg.sensor_present     <= 1'b0;
            cfg_reg.move_limit         <= emt_pkg::THRESHOLD_RST;
            cfg_reg.arrive_window      <= emt_pkg::WINDOW_RST;
            cfg_reg.min_reads_for_rate <= emt_pkg::MIN_READS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hw/rtl/emt_calc.sv @@
// ----------------------------------------------------------------------------
// emt_calc
// Corrected angle, shortest-path direction to the target and magnet status.
// ----------------------------------------------------------------------------
module emt_calc #(
    parameter int ANGLE_BITS = emt_pkg::ANGLE_BITS_DEF
) (
    input  logic [ANGLE_BITS-1:0] raw_angle,
    input  logic [ANGLE_BITS-1:0] target_angle,
    input  logic                  read_failed,
    input  logic                  magnet_detected,
    input  logic                  magnet_weak,
    input  logic                  magnet_strong,
    input  emt_pkg::cfg_t         cfg,
    output logic [ANGLE_BITS-1:0] angle_out,
    output emt_pkg::calc_t        calc
);

    localparam int EXT_W = (ANGLE_BITS > emt_pkg::OFFSET_W) ? ANGLE_BITS : emt_pkg::OFFSET_W;
    localparam int CMP_W = (ANGLE_BITS + 2 > emt_pkg::WINDOW_W) ?
                           ANGLE_BITS + 2 : emt_pkg::WINDOW_W;
    localparam logic signed [ANGLE_BITS+1:0] HALF_S = {3'b001, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [ANGLE_BITS+1:0] FULL_S = {2'b01, {ANGLE_BITS{1'b0}}};

    logic [ANGLE_BITS-1:0]        mirrored;
    logic [EXT_W-1:0]             offset_ext;
    logic [ANGLE_BITS-1:0]        angle_c;
    logic signed [ANGLE_BITS+1:0] t_diff;
    logic signed [ANGLE_BITS+1:0] t_wrap;
    logic signed [ANGLE_BITS+1:0] t_mag;
    logic [CMP_W-1:0]             t_mag_ext;
    logic [CMP_W-1:0]             window_ext;

    assign mirrored   = cfg.invert_direction ? (~raw_angle + 1'b1) : raw_angle;
    assign offset_ext = EXT_W'(cfg.offset_counts);
    assign angle_c    = mirrored - offset_ext[ANGLE_BITS-1:0];
    assign t_diff     = $signed({2'b00, target_angle}) - $signed({2'b00, angle_c});

    always_comb begin
        if (t_diff > HALF_S) begin
            t_wrap = t_diff - FULL_S;
        end else if (t_diff < -HALF_S) begin
            t_wrap = t_diff + FULL_S;
        end else begin
            t_wrap = t_diff;
        end
    end

    assign t_mag      = t_wrap[ANGLE_BITS+1] ? -t_wrap : t_wrap;
    assign t_mag_ext  = CMP_W'($unsigned(t_mag));
    assign window_ext = CMP_W'(cfg.arrive_window);
    assign angle_out  = read_failed ? '0 : angle_c;

    always_comb begin
        if (read_failed || (t_mag_ext < window_ext)) begin
            calc.expected_direction = emt_pkg::DIR_NONE;
        end else if (!t_wrap[ANGLE_BITS+1] && (t_wrap != '0)) begin
            calc.expected_direction = emt_pkg::DIR_CW;
        end else begin
            calc.expected_direction = emt_pkg::DIR_CCW;
        end

        if (!magnet_detected) begin
            calc.magnet_code = emt_pkg::MAG_NONE;
        end else if (magnet_weak) begin
            calc.magnet_code = emt_pkg::MAG_WEAK;
        end else if (magnet_strong) begin
            calc.magnet_code = emt_pkg::MAG_STRONG;
        end else begin
            calc.magnet_code = emt_pkg::MAG_OK;
        end
    end

endmodule

@@ hw/rtl/emt_tracker.sv @@
// ----------------------------------------------------------------------------
// emt_tracker
// Reference angle, movement detection, direction and saturating counters.
// ----------------------------------------------------------------------------
module emt_tracker #(
    parameter int ANGLE_BITS   = emt_pkg::ANGLE_BITS_DEF,
    parameter int COUNTER_BITS = emt_pkg::COUNTER_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step_en,
    input  logic [ANGLE_BITS-1:0]   raw_angle,
    input  logic                    read_failed,
    input  logic                    clear_movement,
    input  logic                    clear_stats,
    input  emt_pkg::cfg_t           cfg,
    output emt_pkg::trk_status_t    status,
    output logic [COUNTER_BITS-1:0] reads_total,
    output logic [COUNTER_BITS-1:0] errors_total
);

    localparam int CMP_W = (ANGLE_BITS + 2 > emt_pkg::THRESHOLD_W) ?
                           ANGLE_BITS + 2 : emt_pkg::THRESHOLD_W;
    localparam logic signed [ANGLE_BITS+1:0] HALF_S = {3'b001, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [ANGLE_BITS+1:0] FULL_S = {2'b01, {ANGLE_BITS{1'b0}}};
    localparam logic [COUNTER_BITS-1:0]      CNT_MAX = '1;

    logic [ANGLE_BITS-1:0]   ref_reg, ref_next;
    logic                    primed_reg, primed_next;
    logic                    flag_reg, flag_next;
    logic [1:0]              dir_reg, dir_next;
    logic [COUNTER_BITS-1:0] rd_reg, rd_next;
    logic [COUNTER_BITS-1:0] er_reg, er_next;

    logic [COUNTER_BITS-1:0]      rd_base;
    logic [COUNTER_BITS-1:0]      er_base;
    logic signed [ANGLE_BITS+1:0] d_diff;
    logic signed [ANGLE_BITS+1:0] d_wrap;
    logic signed [ANGLE_BITS+1:0] d_mag;
    logic                         exceed;
    logic [COUNTER_BITS+3:0]      er_x10;
    logic                         rate_bad;

    assign rd_base = clear_stats ? '0 : rd_reg;
    assign er_base = clear_stats ? '0 : er_reg;
    assign rd_next = (rd_base == CNT_MAX) ? rd_base : rd_base + 1'b1;
    assign er_next = (!read_failed || (er_base == CNT_MAX)) ? er_base : er_base + 1'b1;

    assign d_diff = $signed({2'b00, raw_angle}) - $signed({2'b00, ref_reg});

    always_comb begin
        if (d_diff > HALF_S) begin
            d_wrap = d_diff - FULL_S;
        end else if (d_diff < -HALF_S) begin
            d_wrap = d_diff + FULL_S;
        end else begin
            d_wrap = d_diff;
        end
    end

    assign d_mag  = d_wrap[ANGLE_BITS+1] ? -d_wrap : d_wrap;
    assign exceed = CMP_W'($unsigned(d_mag)) > CMP_W'(cfg.move_limit);

    always_comb begin
        ref_next    = ref_reg;
        primed_next = primed_reg;
        flag_next   = clear_movement ? 1'b0 : flag_reg;
        dir_next    = dir_reg;
        if (!read_failed) begin
            if (!primed_reg) begin
                ref_next    = raw_angle;
                primed_next = 1'b1;
                dir_next    = emt_pkg::DIR_NONE;
            end else if (exceed) begin
                ref_next  = raw_angle;
                flag_next = 1'b1;
                dir_next  = (!d_wrap[ANGLE_BITS+1] && (d_wrap != '0)) ?
                            emt_pkg::DIR_CW : emt_pkg::DIR_CCW;
            end else begin
                dir_next = emt_pkg::DIR_NONE;
            end
        end
    end

    // ten times the error count as 8x + 2x
    assign er_x10   = (COUNTER_BITS+4)'({er_next, 3'b000}) + (COUNTER_BITS+4)'({er_next, 1'b0});
    assign rate_bad = (rd_next > COUNTER_BITS'(cfg.min_reads_for_rate)) &&
                      (er_x10 > (COUNTER_BITS+4)'(rd_next));

    assign status.rotation      = dir_next;
    assign status.movement_seen = flag_next;
    assign status.rate_ok       = ~rate_bad;
    assign reads_total          = rd_next;
    assign errors_total         = er_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg    <= '0;
            primed_reg <= 1'b0;
            flag_reg   <= 1'b0;
            dir_reg    <= emt_pkg::DIR_NONE;
            rd_reg     <= '0;
            er_reg     <= '0;
        end else if (step_en) begin
            ref_reg    <= ref_next;
            primed_reg <= primed_next;
            flag_reg   <= flag_next;
            dir_reg    <= dir_next;
            rd_reg     <= rd_next;
            er_reg     <= er_next;
        end
    end

endmodule

@@ hw/rtl/encoder_angle_motion_tracker_core.sv @@
// ----------------------------------------------------------------------------
// encoder_angle_motion_tracker_core
// Absolute encoder angle correction, movement and direction tracking, health.
// ----------------------------------------------------------------------------
// One sample is taken per clock, sustained, while the result channel is not
// stalled by m_axis_tready. A sample is captured in the input register, and all
// its work (angle correction, wrapped delta against the reference, target
// direction, counters, health) is done combinationally on its way into the
// result register. The tracker state updates as each sample moves into the
// result register, which lets the next sample follow directly. s_axis_tready
// follows m_axis_tready when both registers are full. There is no clearing
// pass after reset.
module encoder_angle_motion_tracker_core #(
    parameter int ANGLE_BITS   = emt_pkg::ANGLE_BITS_DEF,
    parameter int COUNTER_BITS = emt_pkg::COUNTER_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [emt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [emt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // raw_angle, magnet_detected, magnet_weak, magnet_strong, target_angle,
    // clear_movement, clear_stats, zero fill
    input  logic [((2*ANGLE_BITS+5+7)/8)*8-1:0] s_axis_tdata,
    // read_failed
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // angle_out, rotation, movement_seen, expected_direction, healthy,
    // magnet_code, reads_total, errors_total, zero fill
    output logic [((ANGLE_BITS+8+2*COUNTER_BITS+7)/8)*8-1:0] m_axis_tdata,
    // angle_valid
    output logic                           m_axis_tuser
);

    localparam int OUT_W = ((ANGLE_BITS+8+2*COUNTER_BITS+7)/8)*8;

    emt_pkg::cfg_t        cfg;
    emt_pkg::calc_t       calc;
    emt_pkg::trk_status_t status;

    logic                  in_valid_reg, in_valid_next;
    logic [ANGLE_BITS-1:0] raw_reg;
    logic [ANGLE_BITS-1:0] target_reg;
    logic                  failed_reg, det_reg, weak_reg, strong_reg;
    logic                  clr_mov_reg, clr_stats_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_data_reg;
    logic                  out_user_reg;

    logic                    advance;
    logic                    in_xfer;
    logic [ANGLE_BITS-1:0]   angle_c;
    logic [COUNTER_BITS-1:0] reads_total;
    logic [COUNTER_BITS-1:0] errors_total;
    logic                    healthy;
    logic [OUT_W-1:0]        result_data;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            raw_reg       <= s_axis_tdata[ANGLE_BITS-1:0];
            det_reg       <= s_axis_tdata[ANGLE_BITS];
            weak_reg      <= s_axis_tdata[ANGLE_BITS+1];
            strong_reg    <= s_axis_tdata[ANGLE_BITS+2];
            target_reg    <= s_axis_tdata[2*ANGLE_BITS+2:ANGLE_BITS+3];
            clr_mov_reg   <= s_axis_tdata[2*ANGLE_BITS+3];
            clr_stats_reg <= s_axis_tdata[2*ANGLE_BITS+4];
            failed_reg    <= s_axis_tuser;
        end
        if (advance) begin
            out_data_reg <= result_data;
            out_user_reg <= ~failed_reg;
        end
    end

    emt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    emt_calc #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_calc (
        .raw_angle       (raw_reg),
        .target_angle    (target_reg),
        .read_failed     (failed_reg),
        .magnet_detected (det_reg),
        .magnet_weak     (weak_reg),
        .magnet_strong   (strong_reg),
        .cfg             (cfg),
        .angle_out       (angle_c),
        .calc            (calc)
    );

    emt_tracker #(
        .ANGLE_BITS   (ANGLE_BITS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_tracker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (advance),
        .raw_angle      (raw_reg),
        .read_failed    (failed_reg),
        .clear_movement (clr_mov_reg),
        .clear_stats    (clr_stats_reg),
        .cfg            (cfg),
        .status         (status),
        .reads_total    (reads_total),
        .errors_total   (errors_total)
    );

    assign healthy = cfg.sensor_present && status.rate_ok &&
                     (calc.magnet_code == emt_pkg::MAG_OK);

    assign result_data = OUT_W'({errors_total, reads_total, calc.magnet_code, healthy,
                                 calc.expected_direction, status.movement_seen,
                                 status.rotation, angle_c});

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

@@ hw/rtl/emt_checker.sv @@
// ----------------------------------------------------------------------------
// emt_checker
// Port-level checks of the tracker core, bound to the top level.
// ----------------------------------------------------------------------------
module emt_checker #(
    parameter int ANGLE_BITS   = emt_pkg::ANGLE_BITS_DEF,
    parameter int COUNTER_BITS = emt_pkg::COUNTER_BITS_DEF
) (
    input logic                                          aclk,
    input logic                                          aresetn,
    input logic                                          m_axis_tvalid,
    input logic                                          m_axis_tready,
    input logic [((ANGLE_BITS+8+2*COUNTER_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic                                          m_axis_tuser
);

    localparam int A = ANGLE_BITS;
    localparam int C = COUNTER_BITS;

    logic [A-1:0] angle_f;
    logic [1:0]   exp_f;
    logic         healthy_f;
    logic [1:0]   mag_f;
    logic [C-1:0] reads_f;
    logic [C-1:0] errors_f;

    assign angle_f   = m_axis_tdata[A-1:0];
    assign exp_f     = m_axis_tdata[A+4:A+3];
    assign healthy_f = m_axis_tdata[A+5];
    assign mag_f     = m_axis_tdata[A+7:A+6];
    assign reads_f   = m_axis_tdata[A+7+C:A+8];
    assign errors_f  = m_axis_tdata[A+7+2*C:A+8+C];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_failed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> (angle_f == '0) && (exp_f == emt_pkg::DIR_NONE))
        else $error("failed read shows angle or direction");

    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (reads_f != '0) && (errors_f <= reads_f))
        else $error("counter relation broken");

    a_magnet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (mag_f != emt_pkg::MAG_OK) |-> !healthy_f)
        else $error("healthy with magnet fault");

endmodule

bind encoder_angle_motion_tracker_core emt_checker #(
    .ANGLE_BITS   (ANGLE_BITS),
    .COUNTER_BITS (COUNTER_BITS)
) u_emt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ tb/encoder_angle_motion_tracker_core_tb.sv @@
// ----------------------------------------------------------------------------
// encoder_angle_motion_tracker_core_tb
// Streams angle samples through the tracker and compares every result against
// a cycle-free prediction of angle correction, wrapped-delta movement and
// direction, target direction, magnet code, counters and health, over several
// register settings with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module encoder_angle_motion_tracker_core_tb;
    import emt_pkg::*;

    localparam int AW      = ANGLE_BITS_DEF;
    localparam int CW      = COUNTER_BITS_DEF;
    localparam int S_W     = ((2*AW+5+7)/8)*8;
    localparam int M_W     = ((AW+8+2*CW+7)/8)*8;
    localparam int HALF    = 1 << (AW-1);
    localparam int FULL    = 1 << AW;
    localparam int PHASE_N = 230;

    typedef struct packed {
        logic [AW-1:0] raw_angle;
        logic          read_failed;
        logic          magnet_detected;
        logic          magnet_weak;
        logic          magnet_strong;
        logic [AW-1:0] target_angle;
        logic          clear_movement;
        logic          clear_stats;
    } sample_t;

    typedef struct packed {
        logic [AW-1:0] angle_out;
        logic          angle_valid;
        logic [1:0]    rotation;
        logic          movement_seen;
        logic [1:0]    expected_direction;
        logic          healthy;
        logic [1:0]    magnet_code;
        logic [CW-1:0] reads_total;
        logic [CW-1:0] errors_total;
    } track_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_W-1:0]        s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_W-1:0]        m_axis_tdata;
    logic                  m_axis_tuser;

    encoder_angle_motion_tracker_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predicted tracker state and register copy
    cfg_t          cfg_shadow;
    logic [AW-1:0] ref_pos;
    logic          ref_primed;
    logic          moved_flag;
    logic [1:0]    last_turn;
    logic [CW-1:0] n_reads;
    logic [CW-1:0] n_errors;

    sample_t     pending_samples[$];
    track_t      expected_tracks[$];
    sample_t     in_flight;
    int unsigned accepted_cnt = 0;
    int unsigned mismatches = 0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          src_gap = 0;
    int          snk_gap = 0;
    logic        hold_on = 1'b0;
    logic [AW-1:0] gen_raw = '0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int shortest_turn(int d);
        if (d > HALF) return d - FULL;
        if (d < -HALF) return d + FULL;
        return d;
    endfunction

    function automatic track_t track_sample(sample_t s);
        track_t        r;
        logic [AW-1:0] a;
        logic [63:0]   err_x10;
        int            d;
        int            t;
        r = '0;
        if (s.clear_stats) begin
            n_reads  = '0;
            n_errors = '0;
        end
        if (s.clear_movement) moved_flag = 1'b0;
        if (n_reads != '1) n_reads = n_reads + 1'b1;
        if (s.read_failed && n_errors != '1) n_errors = n_errors + 1'b1;
        r.expected_direction = DIR_NONE;
        if (!s.read_failed) begin
            a = cfg_shadow.invert_direction ? (AW'(0) - s.raw_angle) : s.raw_angle;
            r.angle_out = a - cfg_shadow.offset_counts;
            if (!ref_primed) begin
                ref_pos    = s.raw_angle;
                ref_primed = 1'b1;
                last_turn  = DIR_NONE;
            end else begin
                d = shortest_turn(int'(s.raw_angle) - int'(ref_pos));
                if ((d < 0 ? -d : d) > int'(cfg_shadow.move_limit)) begin
                    moved_flag = 1'b1;
                    last_turn  = (d > 0) ? DIR_CW : DIR_CCW;
                    ref_pos    = s.raw_angle;
                end else begin
                    last_turn = DIR_NONE;
                end
            end
            t = shortest_turn(int'(s.target_angle) - int'(r.angle_out));
            if ((t < 0 ? -t : t) >= int'(cfg_shadow.arrive_window))
                r.expected_direction = (t > 0) ? DIR_CW : DIR_CCW;
        end
        if (!s.magnet_detected) r.magnet_code = MAG_NONE;
        else if (s.magnet_weak) r.magnet_code = MAG_WEAK;
        else if (s.magnet_strong) r.magnet_code = MAG_STRONG;
        else r.magnet_code = MAG_OK;
        err_x10 = 64'(n_errors) * 10;
        r.healthy = cfg_shadow.sensor_present;
        if (n_reads > CW'(cfg_shadow.min_reads_for_rate) && err_x10 > 64'(n_reads))
            r.healthy = 1'b0;
        if (r.magnet_code != MAG_OK) r.healthy = 1'b0;
        r.angle_valid   = ~s.read_failed;
        r.rotation      = last_turn;
        r.movement_seen = moved_flag;
        r.reads_total   = n_reads;
        r.errors_total  = n_errors;
        return r;
    endfunction

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sample_t mk(int raw, bit failed, bit det, bit mag_weak, bit mag_strong,
                                   int target, bit clr_mov, bit clr_stats);
        sample_t s;
        s.raw_angle       = AW'(raw);
        s.read_failed     = failed;
        s.magnet_detected = det;
        s.magnet_weak     = mag_weak;
        s.magnet_strong   = mag_strong;
        s.target_angle    = AW'(target);
        s.clear_movement  = clr_mov;
        s.clear_stats     = clr_stats;
        return s;
    endfunction

    // small steps around the last sample in half of the picks so the threshold decides
    function automatic sample_t random_sample(int fail_pct);
        sample_t s;
        int      span;
        int      pick;
        pick = $urandom_range(0, 99);
        span = int'(cfg_shadow.move_limit) + 3;
        if (pick < 50)
            s.raw_angle = gen_raw + AW'(int'($urandom_range(0, 2*span)) - span);
        else if (pick < 60)
            s.raw_angle = gen_raw + AW'(HALF - 1 + int'($urandom_range(0, 2)));
        else
            s.raw_angle = AW'($urandom_range(0, FULL-1));
        gen_raw           = s.raw_angle;
        s.read_failed     = $urandom_range(0, 99) < fail_pct;
        s.magnet_detected = $urandom_range(0, 9) != 0;
        s.magnet_weak     = $urandom_range(0, 9) == 0;
        s.magnet_strong   = $urandom_range(0, 9) == 0;
        if ($urandom_range(0, 3) == 0)
            s.target_angle = s.raw_angle + AW'(int'($urandom_range(0, 140)) - 70);
        else
            s.target_angle = AW'($urandom_range(0, FULL-1));
        s.clear_movement  = $urandom_range(0, 19) == 0;
        s.clear_stats     = $urandom_range(0, 49) == 0;
        return s;
    endfunction

    function automatic void check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // sample driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_tracks.push_back(track_sample(in_flight));
                accepted_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    in_flight = pending_samples.pop_front();
                    s_axis_tdata <= {3'b000, in_flight.clear_stats, in_flight.clear_movement,
                                     in_flight.target_angle, in_flight.magnet_strong,
                                     in_flight.magnet_weak, in_flight.magnet_detected,
                                     in_flight.raw_angle};
                    s_axis_tuser  <= in_flight.read_failed;
                    s_axis_tvalid <= 1'b1;
                    src_gap = pick_gap(src_idle_pct);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : result_monitor
        track_t got;
        track_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.angle_out          = m_axis_tdata[11:0];
            got.rotation           = m_axis_tdata[13:12];
            got.movement_seen      = m_axis_tdata[14];
            got.expected_direction = m_axis_tdata[16:15];
            got.healthy            = m_axis_tdata[17];
            got.magnet_code        = m_axis_tdata[19:18];
            got.reads_total        = m_axis_tdata[51:20];
            got.errors_total       = m_axis_tdata[83:52];
            got.angle_valid        = m_axis_tuser;
            if (expected_tracks.size() == 0) begin
                $display("%0t: result transfer with nothing expected, data 0x%0h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_tracks.pop_front();
                check_field("angle_out", CW'(want.angle_out), CW'(got.angle_out));
                check_field("angle_valid", CW'(want.angle_valid), CW'(got.angle_valid));
                check_field("rotation", CW'(want.rotation), CW'(got.rotation));
                check_field("movement_seen", CW'(want.movement_seen), CW'(got.movement_seen));
                check_field("expected_direction", CW'(want.expected_direction),
                            CW'(got.expected_direction));
                check_field("healthy", CW'(want.healthy), CW'(got.healthy));
                check_field("magnet_code", CW'(want.magnet_code), CW'(got.magnet_code));
                check_field("reads_total", want.reads_total, got.reads_total);
                check_field("errors_total", want.errors_total, got.errors_total);
            end
        end
        if (!aresetn || hold_on) begin
            m_axis_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            snk_gap = pick_gap(snk_idle_pct);
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (accepted_cnt >= 300);
        @(negedge aclk);
        hold_on = 1'b1;
        repeat (300) @(negedge aclk);
        hold_on = 1'b0;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_OFFSET:    cfg_shadow.offset_counts      = OFFSET_W'(val);
            CFG_INVERT:    cfg_shadow.invert_direction   = val[0];
            CFG_PRESENT:   cfg_shadow.sensor_present     = val[0];
            CFG_THRESHOLD: cfg_shadow.move_limit         = THRESHOLD_W'(val);
            CFG_WINDOW:    cfg_shadow.arrive_window      = WINDOW_W'(val);
            CFG_MIN_READS: cfg_shadow.min_reads_for_rate = MIN_READS_W'(val);
            default: ;
        endcase
    endtask

    task automatic apply_setup(int unsigned offs, int unsigned inv, int unsigned pres,
                               int unsigned thr, int unsigned win, int unsigned minr);
        write_reg(CFG_OFFSET, offs);
        write_reg(CFG_INVERT, inv);
        write_reg(CFG_PRESENT, pres);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_MIN_READS, minr);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_samples.size() > 0 || s_axis_tvalid || expected_tracks.size() > 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_random(int n, int src_pct, int snk_pct, int fail_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int i = 0; i < n; i++) pending_samples.push_back(random_sample(fail_pct));
        wait_drained();
    endtask

    initial begin
        cfg_shadow.offset_counts      = '0;
        cfg_shadow.invert_direction   = 1'b0;
        cfg_shadow.sensor_present     = 1'b0;
        cfg_shadow.move_limit         = THRESHOLD_RST;
        cfg_shadow.arrive_window      = WINDOW_RST;
        cfg_shadow.min_reads_for_rate = MIN_READS_RST;
        ref_pos    = '0;
        ref_primed = 1'b0;
        moved_flag = 1'b0;
        last_turn  = DIR_NONE;
        n_reads    = '0;
        n_errors   = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: wrap edges, half-scale deltas, threshold and window edges, clears, failed reads, magnet codes
        apply_setup(0, 0, 1, 5, 57, 10);
        src_idle_pct = 15;
        snk_idle_pct = 15;
        pending_samples.push_back(mk(4095, 1, 1, 0, 0, 0,    0, 0));
        pending_samples.push_back(mk(0,    0, 1, 0, 0, 2048, 0, 0));
        pending_samples.push_back(mk(6,    0, 1, 0, 0, 0,    0, 0));
        pending_samples.push_back(mk(0,    0, 1, 0, 0, 0,    0, 0));
        pending_samples.push_back(mk(4095, 0, 1, 0, 0, 4095, 0, 0));
        pending_samples.push_back(mk(2048, 0, 1, 0, 0, 0,    0, 0));
        pending_samples.push_back(mk(0,    0, 1, 0, 0, 2048, 0, 0));
        pending_samples.push_back(mk(4095, 0, 1, 0, 0, 2047, 0, 0));
        pending_samples.push_back(mk(100,  1, 1, 0, 0, 50,   1, 0));
        pending_samples.push_back(mk(5,    0, 1, 0, 0, 62,   0, 0));
        pending_samples.push_back(mk(6,    0, 1, 0, 0, 62,   1, 0));
        pending_samples.push_back(mk(12,   0, 1, 0, 0, 4095, 0, 1));
        pending_samples.push_back(mk(12,   0, 0, 0, 0, 12,   0, 0));
        pending_samples.push_back(mk(12,   0, 1, 1, 0, 12,   0, 0));
        pending_samples.push_back(mk(12,   0, 1, 0, 1, 12,   0, 0));
        pending_samples.push_back(mk(12,   0, 1, 1, 1, 12,   0, 0));
        pending_samples.push_back(mk(12,   0, 0, 1, 1, 12,   0, 0));
        for (int i = 0; i < 6; i++)
            pending_samples.push_back(mk($urandom_range(0, FULL-1), 1, 1, 0, 0,
                                         $urandom_range(0, FULL-1), 0, 0));
        pending_samples.push_back(mk(20, 0, 1, 0, 0, 20, 0, 0));
        wait_drained();

        apply_setup(0, 0, 1, 5, 57, 10);
        run_random(PHASE_N, 20, 20, 8);
        apply_setup(4095, 1, 1, 2047, 2048, 255);
        run_random(PHASE_N, 0, 0, 15);
        apply_setup(0, 0, 0, 0, 0, 0);
        run_random(PHASE_N, 30, 10, 12);
        for (int p = 0; p < 3; p++) begin
            apply_setup($urandom_range(0, 4095), $urandom_range(0, 1), $urandom_range(0, 1),
                        $urandom_range(0, 64), $urandom_range(0, 2048),
                        $urandom_range(0, 255));
            run_random(PHASE_N, (p == 2) ? 0 : 10 + 15*p, 10 + 15*p,
                       $urandom_range(3, 25));
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_tracks.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
